// ----- src/bale_pkg.sv -----
// bounded array list engine: shared types and constants
// operation and status codes, controller states, cell control and result records
// no dependencies
package bale_pkg;

  localparam int unsigned DEF_CAPACITY = 1024;

  typedef enum logic [2:0] {
    OP_APPEND      = 3'd0,
    OP_READ        = 3'd1,
    OP_WRITE       = 3'd2,
    OP_ERASE_ONE   = 3'd3,
    OP_ERASE_RANGE = 3'd4,
    OP_TRUNCATE    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2,
    ST_TRUNC  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_READ   = 2'd1,
    S_SHIFT  = 2'd2,
    S_FINISH = 2'd3
  } state_e;

  // broadcast controls for the row of cells
  typedef struct packed {
    logic write_en;
    logic shift_en;
    logic rb_load;
    logic rb_shift;
  } cell_ctrl_t;

  // one result record
  typedef struct packed {
    logic signed [31:0] read_word;
    logic [10:0]        length;
    status_e            status;
  } rsp_t;

endpackage

// ----- src/bale_if.sv -----
// bounded array list engine: request and response channel interfaces
// valid/ready handshake with the payload fields of each transaction
// no dependencies
interface bale_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [9:0]         position;
  logic [9:0]         last_position;
  logic [10:0]        target_length;
  logic signed [31:0] word;

  modport source (output valid, kind, position, last_position, target_length, word,
                  input ready);
  modport sink   (input valid, kind, position, last_position, target_length, word,
                  output ready);
endinterface

interface bale_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_word;
  logic [10:0]        length;
  logic [1:0]         status;

  modport source (output valid, read_word, length, status, input ready);
  modport sink   (input valid, read_word, length, status, output ready);
endinterface

// ----- src/bale_cell.sv -----
// bounded array list engine: one storage cell of the list
// holds one element and one stage of the read bus; uses bale_pkg
// takes data from its upper neighbour when the list closes a gap
module bale_cell import bale_pkg::*; #(
  parameter int unsigned AW  = 10,
  parameter int unsigned IDX = 0
) (
  input  logic          clk_i,
  input  cell_ctrl_t    ctrl_i,
  input  logic [AW-1:0] write_idx_i,
  input  logic [31:0]   write_word_i,
  input  logic [AW-1:0] shift_from_i,
  input  logic [AW-1:0] rb_pos_i,
  input  logic [31:0]   next_data_i,
  input  logic [31:0]   next_rb_i,
  output logic [31:0]   data_o,
  output logic [31:0]   rb_o
);

  localparam logic [AW-1:0] IDX_C = AW'(IDX);

  logic [31:0] data_q;
  logic [31:0] rb_q;

  // element: direct write, or move down from the neighbour above
  always_ff @(posedge clk_i) begin
    if (ctrl_i.write_en && (write_idx_i == IDX_C)) begin
      data_q <= write_word_i;
    end else if (ctrl_i.shift_en && (IDX_C >= shift_from_i)) begin
      data_q <= next_data_i;
    end
  end

  // read bus: the addressed cell loads its element, then the bus moves down
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rb_load) begin
      rb_q <= (rb_pos_i == IDX_C) ? data_q : '0;
    end else if (ctrl_i.rb_shift) begin
      rb_q <= next_rb_i;
    end
  end

  assign data_o = data_q;
  assign rb_o   = rb_q;

endmodule

// ----- src/bale_chain.sv -----
// bounded array list engine: row of storage cells
// links each cell to its upper neighbour; uses bale_pkg and bale_cell
// the read bus leaves the row at cell zero
module bale_chain import bale_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk_i,
  input  cell_ctrl_t                  ctrl_i,
  input  logic [$clog2(CAPACITY)-1:0] write_idx_i,
  input  logic [31:0]                 write_word_i,
  input  logic [$clog2(CAPACITY)-1:0] shift_from_i,
  input  logic [$clog2(CAPACITY)-1:0] rb_pos_i,
  output logic [31:0]                 rb_head_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic [31:0] data_w [CAPACITY+1];
  logic [31:0] rb_w   [CAPACITY+1];

  // nothing above the top cell
  assign data_w[CAPACITY] = '0;
  assign rb_w[CAPACITY]   = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bale_cell #(
      .AW  (AW),
      .IDX (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl_i),
      .write_idx_i  (write_idx_i),
      .write_word_i (write_word_i),
      .shift_from_i (shift_from_i),
      .rb_pos_i     (rb_pos_i),
      .next_data_i  (data_w[i+1]),
      .next_rb_i    (rb_w[i+1]),
      .data_o       (data_w[i]),
      .rb_o         (rb_w[i])
    );
  end

  assign rb_head_o = rb_w[0];

endmodule

// ----- src/bounded_array_list_engine_top.sv -----
// bounded array list engine: top level with controller and output register
// uses bale_pkg, bale_req_if, bale_rsp_if and bale_chain
//
// Usage: one request transaction on req_i (kind, position, last_position,
// target_length, word) gives exactly one response transaction on rsp_o
// (read_word, length, status), in order.
// Steps from acceptance to response valid:
//   append, write, truncate, unused kinds and every error: straight to finish
//   read: the read bus moving one cell per cycle, then finish
//   erase one or range: the row shifting down one cell per cycle
//   for each erased element, then finish
// Requests are worked one at a time; the next waits for the last to finish.
// req_i.ready is high while the controller has no request in hand.
// Reset clears the element count and the response valid; the cell row
// holds no reset value and every element is written before it is read.
// A stalled receiver keeps the response in the output register; the next
// request is still accepted and worked, and its result waits until the
// output register is free.
module bounded_array_list_engine_top import bale_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bale_req_if.sink   req_i,
  bale_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CW > 11) ? CW : 11;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] shift_from_q, shift_from_d;
  rsp_t          res_q, res_d;
  rsp_t          out_q;
  logic          out_valid_q;
  logic          load_out;

  cell_ctrl_t    ctrl;
  logic [AW-1:0] write_idx;
  logic [AW-1:0] rb_pos;
  logic [31:0]   rb_head;

  logic [IW-1:0] pos_w, last_w, tgt_w, len_w, gap_w;

  assign pos_w  = IW'(req_i.position);
  assign last_w = IW'(req_i.last_position);
  assign tgt_w  = IW'(req_i.target_length);
  assign len_w  = IW'(count_q);
  assign gap_w  = last_w - pos_w + IW'(1);

  assign req_i.ready = (state_q == S_IDLE);
  assign rb_pos      = AW'(req_i.position);

  // next state, list bookkeeping and cell controls
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cnt_d        = cnt_q;
    shift_from_d = shift_from_q;
    res_d        = res_q;
    ctrl         = '0;
    write_idx    = AW'(req_i.position);
    load_out     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          res_d.read_word = '0;
          res_d.status    = ST_OK;
          state_d         = S_FINISH;
          unique case (op_e'(req_i.kind))
            OP_APPEND: begin
              if (count_q == CW'(CAPACITY)) begin
                res_d.status = ST_FULL;
              end else begin
                ctrl.write_en = 1'b1;
                write_idx     = AW'(count_q);
                count_d       = count_q + CW'(1);
              end
            end
            OP_READ: begin
              if (pos_w >= len_w) begin
                res_d.status = ST_BOUNDS;
              end else begin
                ctrl.rb_load = 1'b1;
                cnt_d        = CW'(req_i.position);
                state_d      = S_READ;
              end
            end
            OP_WRITE: begin
              if (pos_w >= len_w) begin
                res_d.status = ST_BOUNDS;
              end else begin
                ctrl.write_en = 1'b1;
              end
            end
            OP_ERASE_ONE: begin
              if (pos_w >= len_w) begin
                res_d.status = ST_BOUNDS;
              end else begin
                shift_from_d = AW'(req_i.position);
                cnt_d        = CW'(1);
                count_d      = count_q - CW'(1);
                state_d      = S_SHIFT;
              end
            end
            OP_ERASE_RANGE: begin
              if ((pos_w >= len_w) || (last_w >= len_w) || (last_w < pos_w)) begin
                res_d.status = ST_BOUNDS;
              end else begin
                shift_from_d = AW'(req_i.position);
                cnt_d        = CW'(gap_w);
                count_d      = count_q - CW'(gap_w);
                state_d      = S_SHIFT;
              end
            end
            OP_TRUNCATE: begin
              if (tgt_w > IW'(CAPACITY)) begin
                res_d.status = ST_TRUNC;
              end else if (tgt_w < len_w) begin
                count_d = CW'(req_i.target_length);
              end
            end
            default: begin
              // unused kinds leave the list alone
            end
          endcase
          res_d.length = 11'(count_d);
        end
      end
      S_READ: begin
        if (cnt_q == '0) begin
          res_d.read_word = rb_head;
          state_d         = S_FINISH;
        end else begin
          ctrl.rb_shift = 1'b1;
          cnt_d         = cnt_q - CW'(1);
        end
      end
      S_SHIFT: begin
        ctrl.shift_en = 1'b1;
        cnt_d         = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    shift_from_q <= shift_from_d;
    res_q        <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  bale_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .write_idx_i  (write_idx),
    .write_word_i (req_i.word),
    .shift_from_i (shift_from_q),
    .rb_pos_i     (rb_pos),
    .rb_head_o    (rb_head)
  );

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_word = out_q.read_word;
  assign rsp_o.length    = out_q.length;
  assign rsp_o.status    = out_q.status;

  // the list never grows past its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  // the length is settled before the row starts to shift
  a_shift_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |=> $stable(count_q))
    else $error("element count changed during a shift");

  // a shift pass always has elements left to move
  a_shift_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (cnt_q != '0))
    else $error("shift pass with no gap left");

  // a finished result reaches the output register once it is free
  a_result_delivered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FINISH) && (!out_valid_q || rsp_o.ready)) |=>
      (out_valid_q && (state_q == S_IDLE)))
    else $error("finished result not moved to the output register");

endmodule
